@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true implies cons true in the same cycle
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// ante true implies cons true in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// expr never true
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ design/rdc_pkg.sv @@
// ----------------------------------------------------------------------------
// rdc_pkg
// Types and constants shared by the radix digit converter modules.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int DIGIT_W       = 8;
  localparam int BASE_W        = 8;
  localparam int BITS_PER_STEP = 8;
  localparam logic [BASE_W-1:0] MIN_BASE = 8'd2;

  // job class decided at the front
  typedef enum logic [1:0] {
    KIND_ERROR,
    KIND_ZERO,
    KIND_DIGITS
  } rdc_kind_t;

  typedef struct packed {
    rdc_kind_t          kind;
    logic [BASE_W-1:0]  base;
  } rdc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rdc_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_EMIT,
    ST_ONE
  } rdc_state_t;

endpackage

@@ design/radix_digit_converter.sv @@
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value into its digits in a given base, most
// significant first, by repeated division onto a digit stack.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: raise push with in_value/in_base; the transaction completes
//   at an edge with push high and full low; two requests can wait up front.
//   Result queue: while empty is low, out_digit/out_last/out_error show the
//   oldest result; pop high with empty low takes it. out_last marks the
//   final digit. A base below 2 gives one result with out_error set; a zero
//   value gives the single digit 0.
//   Each division runs in the iterative divider and each digit is popped
//   from the stack through a read register; the back end takes no new
//   request until the last digit or the error/zero result is loaded.
//   A stalled receiver holds one result in the output register and the
//   back end waits; the front keeps accepting until its queue is full.
//   Reset (rst_n low, synchronous) empties both queues and idles the back.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_WIDTH = 32,
  parameter int STACK_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  input  logic [rdc_pkg::BASE_W-1:0]    in_base,
  output logic                          empty,
  input  logic                          pop,
  output logic [rdc_pkg::DIGIT_W-1:0]   out_digit,
  output logic                          out_last,
  output logic                          out_error
);
  import rdc_pkg::*;

  logic                   cmd_valid;
  logic                   cmd_ready;
  rdc_cmd_t               cmd;
  logic [VALUE_WIDTH-1:0] cmd_value;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic [BASE_W-1:0]      div_base;
  rdc_div_stat_t          div_stat;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [DIGIT_W-1:0]     div_remainder;

  rdc_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_value  (in_value),
    .in_base   (in_base),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cmd_value (cmd_value)
  );

  rdc_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .base      (div_base),
    .stat      (div_stat),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  rdc_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd),
    .cmd_value     (cmd_value),
    .div_start     (div_start),
    .div_dividend  (div_dividend),
    .div_base      (div_base),
    .div_stat      (div_stat),
    .div_quotient  (div_quotient),
    .div_remainder (div_remainder),
    .empty         (empty),
    .pop           (pop),
    .out_digit     (out_digit),
    .out_last      (out_last),
    .out_error     (out_error)
  );

endmodule

@@ design/rdc_front.sv @@
// ----------------------------------------------------------------------------
// rdc_front
// Accepts conversion requests, classifies them and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [VALUE_WIDTH-1:0]        in_value,
  input  logic [rdc_pkg::BASE_W-1:0]    in_base,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output rdc_pkg::rdc_cmd_t             cmd,
  output logic [VALUE_WIDTH-1:0]        cmd_value
);
  import rdc_pkg::*;

  rdc_cmd_t               cmd_q [2];
  logic [VALUE_WIDTH-1:0] val_q [2];
  logic                   wr_ptr_r;
  logic                   rd_ptr_r;
  logic [1:0]             cnt_r;
  logic                   push_acc;
  logic                   pop_acc;
  rdc_cmd_t               new_cmd;

  assign full      = (cnt_r == 2'd2);
  assign push_acc  = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_acc   = cmd_valid && cmd_ready;
  assign cmd       = cmd_q[rd_ptr_r];
  assign cmd_value = val_q[rd_ptr_r];

  always_comb begin
    new_cmd.base = in_base;
    if (in_base < MIN_BASE) begin
      new_cmd.kind = KIND_ERROR;
    end else if (in_value == '0) begin
      new_cmd.kind = KIND_ZERO;
    end else begin
      new_cmd.kind = KIND_DIGITS;
    end
  end

  always_ff @(posedge clk) begin
    if (push_acc) begin
      cmd_q[wr_ptr_r] <= new_cmd;
      val_q[wr_ptr_r] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_acc) wr_ptr_r <= !wr_ptr_r;
      if (pop_acc)  rd_ptr_r <= !rd_ptr_r;
      if (push_acc && !pop_acc) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop_acc && !push_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  `ASSERT_NEVER(a_cnt_range, clk, rst_n, cnt_r == 2'd3)
  `ASSERT_NEXT(a_fill, clk, rst_n, push_acc && !pop_acc, cnt_r == $past(cnt_r) + 2'd1)
  `ASSERT_IMPLIES(a_ptr_match, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wr_ptr_r == rd_ptr_r)

endmodule

@@ design/rdc_divider.sv @@
// ----------------------------------------------------------------------------
// rdc_divider
// Iterative divider by an 8-bit base, eight quotient bits per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_divider #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [VALUE_WIDTH-1:0]        dividend,
  input  logic [rdc_pkg::BASE_W-1:0]    base,
  output rdc_pkg::rdc_div_stat_t        stat,
  output logic [VALUE_WIDTH-1:0]        quotient,
  output logic [rdc_pkg::DIGIT_W-1:0]   remainder
);
  import rdc_pkg::*;

  localparam int STEPS   = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W   = STEPS * BITS_PER_STEP;
  localparam int STEP_CW = $clog2(STEPS + 1);

  // work_r: dividend bits shift out at the top, quotient bits enter at the bottom
  logic [DIV_W-1:0]   work_r;
  logic [DIGIT_W-1:0] rem_r;
  logic [BASE_W-1:0]  base_r;
  logic [STEP_CW-1:0] cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [DIV_W-1:0]   work_nxt;
  logic [DIGIT_W-1:0] rem_nxt;

  always_comb begin
    logic [DIGIT_W:0] r9;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r9       = {rem_nxt, work_nxt[DIV_W-1]};
      work_nxt = {work_nxt[DIV_W-2:0], 1'b0};
      if (r9 >= {1'b0, base_r}) begin
        r9          = r9 - {1'b0, base_r};
        work_nxt[0] = 1'b1;
      end
      rem_nxt = r9[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      work_r <= DIV_W'(dividend);
      rem_r  <= '0;
      base_r <= base;
    end else if (busy_r) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_CW'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_CW'(1);
        if (cnt_r == STEP_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = work_r[VALUE_WIDTH-1:0];
  assign remainder = rem_r;

  `ASSERT_NEVER(a_done_busy, clk, rst_n, done_r && busy_r)
  `ASSERT_IMPLIES(a_rem_lt_base, clk, rst_n, done_r, rem_r < base_r)
  `ASSERT_IMPLIES(a_cnt_live, clk, rst_n, busy_r, cnt_r != '0)

endmodule

@@ design/rdc_back.sv @@
// ----------------------------------------------------------------------------
// rdc_back
// Runs one conversion: repeated division onto the digit stack, then pops
// the stack into the result register, most significant digit first.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdc_back #(
  parameter int VALUE_WIDTH = 32,
  parameter int STACK_DEPTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  rdc_pkg::rdc_cmd_t             cmd,
  input  logic [VALUE_WIDTH-1:0]        cmd_value,
  output logic                          div_start,
  output logic [VALUE_WIDTH-1:0]        div_dividend,
  output logic [rdc_pkg::BASE_W-1:0]    div_base,
  input  rdc_pkg::rdc_div_stat_t        div_stat,
  input  logic [VALUE_WIDTH-1:0]        div_quotient,
  input  logic [rdc_pkg::DIGIT_W-1:0]   div_remainder,
  output logic                          empty,
  input  logic                          pop,
  output logic [rdc_pkg::DIGIT_W-1:0]   out_digit,
  output logic                          out_last,
  output logic                          out_error
);
  import rdc_pkg::*;

  localparam int PTR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [DIGIT_W-1:0] stack_mem [STACK_DEPTH];

  rdc_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   sp_r, sp_nxt;
  logic [CNT_W-1:0]   sp_dec;
  logic [BASE_W-1:0]  base_r, base_nxt;
  logic               one_err_r, one_err_nxt;
  logic [DIGIT_W-1:0] rd_data_r;
  logic               out_valid_r;
  logic [DIGIT_W-1:0] out_digit_r;
  logic               out_last_r;
  logic               out_error_r;

  logic               mem_wr;
  logic               mem_rd;
  logic               slot_free;
  logic               load_out;
  logic [DIGIT_W-1:0] ld_digit;
  logic               ld_last;
  logic               ld_err;

  assign slot_free = !out_valid_r || pop;
  assign sp_dec    = sp_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sp_nxt       = sp_r;
    base_nxt     = base_r;
    one_err_nxt  = one_err_r;
    cmd_ready    = 1'b0;
    div_start    = 1'b0;
    div_dividend = cmd_value;
    div_base     = base_r;
    mem_wr       = 1'b0;
    mem_rd       = 1'b0;
    load_out     = 1'b0;
    ld_digit     = '0;
    ld_last      = 1'b0;
    ld_err       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd_ready = 1'b1;
        div_base  = cmd.base;
        if (cmd_valid) begin
          base_nxt = cmd.base;
          case (cmd.kind)
            KIND_DIGITS: begin
              div_start = 1'b1;
              sp_nxt    = '0;
              state_nxt = ST_DIV;
            end
            KIND_ERROR: begin
              one_err_nxt = 1'b1;
              state_nxt   = ST_ONE;
            end
            default: begin
              one_err_nxt = 1'b0;
              state_nxt   = ST_ONE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          mem_wr = 1'b1;
          sp_nxt = sp_r + CNT_W'(1);
          // stop on a zero quotient or a full stack
          if (div_quotient == '0 || sp_r + CNT_W'(1) == CNT_W'(STACK_DEPTH)) begin
            state_nxt = ST_RD;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quotient;
          end
        end
      end
      ST_RD: begin
        mem_rd    = 1'b1;
        sp_nxt    = sp_dec;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ld_digit  = rd_data_r;
          ld_last   = (sp_r == '0);
          state_nxt = (sp_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          load_out  = 1'b1;
          ld_last   = 1'b1;
          ld_err    = one_err_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    one_err_r <= one_err_nxt;
  end

  // digit stack
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      stack_mem[sp_r[PTR_W-1:0]] <= div_remainder;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data_r <= stack_mem[sp_dec[PTR_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_digit_r <= ld_digit;
      out_last_r  <= ld_last;
      out_error_r <= ld_err;
    end
  end

  assign empty     = !out_valid_r;
  assign out_digit = out_digit_r;
  assign out_last  = out_last_r;
  assign out_error = out_error_r;

  `ASSERT_NEVER(a_start_busy, clk, rst_n, div_start && div_stat.busy)
  `ASSERT_NEVER(a_sp_range, clk, rst_n, sp_r > CNT_W'(STACK_DEPTH))
  `ASSERT_IMPLIES(a_rd_nonempty, clk, rst_n, mem_rd, sp_r != '0)

endmodule
